[design/pidcs_pkg.sv]
package pidcs_pkg;

  localparam int STEP_W = 3;

  // Filter coefficients, Q0.16 (they sum to one)
  localparam logic signed [32:0] COEF_NEW = 33'sd45875;
  localparam logic signed [32:0] COEF_OLD = 33'sd19661;

  // Multiplier operand A sources
  localparam logic [2:0] A_NONE = 3'd0;
  localparam logic [2:0] A_KI   = 3'd1;
  localparam logic [2:0] A_KP   = 3'd2;
  localparam logic [2:0] A_KD   = 3'd3;
  localparam logic [2:0] A_NEW  = 3'd4;
  localparam logic [2:0] A_OLD  = 3'd5;

  // Multiplier operand B sources
  localparam logic [1:0] B_ERR  = 2'd0;
  localparam logic [1:0] B_DIFF = 2'd1;
  localparam logic [1:0] B_FILT = 2'd2;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [1:0] b_sel;
    logic       clr_jump;      // leave the program and clear state on a clear command
    logic       ld_err;
    logic       ld_diff;
    logic       upd_int;
    logic       acc_from_p;
    logic       upd_filt;
    logic       acc_from_int;
    logic       acc_add;
    logic       finish;
  } ctrl_word_t;

  // Control store: one word per step of a control update
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '0;
    unique case (step)
      3'd0: begin
        cw.ld_err   = 1'b1;
        cw.clr_jump = 1'b1;
      end
      3'd1: begin
        cw.a_sel   = A_KI;
        cw.b_sel   = B_ERR;
        cw.ld_diff = 1'b1;
      end
      3'd2: begin
        cw.upd_int = 1'b1;
        cw.a_sel   = A_NEW;
        cw.b_sel   = B_DIFF;
      end
      3'd3: begin
        cw.acc_from_p = 1'b1;
        cw.a_sel      = A_OLD;
        cw.b_sel      = B_FILT;
      end
      3'd4: begin
        cw.upd_filt = 1'b1;
        cw.a_sel    = A_KP;
        cw.b_sel    = B_ERR;
      end
      3'd5: begin
        cw.acc_from_int = 1'b1;
        cw.a_sel        = A_KD;
        cw.b_sel        = B_FILT;
      end
      3'd6: begin
        cw.acc_add = 1'b1;
      end
      3'd7: begin
        cw.finish = 1'b1;
      end
      default: cw = '0;
    endcase
    return cw;
  endfunction

endpackage

[design/pidcs_datapath.sv]
module pidcs_datapath
  import pidcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               clear,
  input  logic               load,
  input  ctrl_word_t         cw,
  input  logic signed [31:0] setpoint,
  input  logic signed [31:0] measurement,
  input  logic signed [31:0] proportional_gain,
  input  logic signed [31:0] integral_gain,
  input  logic signed [31:0] derivative_gain,
  input  logic        [30:0] windup_limit,
  input  logic signed [31:0] output_upper,
  input  logic signed [31:0] output_lower,
  output logic signed [31:0] drive_value
);

  logic signed [31:0] sp;
  logic signed [31:0] meas;
  logic signed [31:0] err;
  logic signed [32:0] diff;
  logic signed [65:0] prod;
  logic signed [51:0] acc;

  logic signed [31:0] integral_sum;
  logic signed [31:0] last_error;
  logic signed [31:0] filtered_difference;

  logic signed [32:0] op_a;
  logic signed [32:0] op_b;
  logic signed [32:0] sp_diff;
  logic signed [31:0] err_next;
  logic signed [65:0] prod_bias;
  logic signed [49:0] rnd;
  logic signed [50:0] int_sum;
  logic signed [50:0] wl_pos;
  logic signed [50:0] wl_neg;
  logic signed [31:0] integral_sum_next;
  logic signed [51:0] fsum;
  logic signed [35:0] fshift;
  logic signed [31:0] filt_next;
  logic signed [51:0] up_ext;
  logic signed [51:0] lo_ext;

  always_comb begin
    unique case (cw.a_sel)
      A_KI:    op_a = {integral_gain[31], integral_gain};
      A_KP:    op_a = {proportional_gain[31], proportional_gain};
      A_KD:    op_a = {derivative_gain[31], derivative_gain};
      A_NEW:   op_a = COEF_NEW;
      A_OLD:   op_a = COEF_OLD;
      default: op_a = '0;
    endcase
    unique case (cw.b_sel)
      B_ERR:   op_b = {err[31], err};
      B_DIFF:  op_b = diff;
      B_FILT:  op_b = {filtered_difference[31], filtered_difference};
      default: op_b = '0;
    endcase
  end

  // Error, saturated to 32 bits
  assign sp_diff = {sp[31], sp} - {meas[31], meas};
  always_comb begin
    if (sp_diff[32] != sp_diff[31]) begin
      err_next = sp_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_next = sp_diff[31:0];
    end
  end

  // Round half up back to Q16.16
  assign prod_bias = prod + 66'sd32768;
  assign rnd       = prod_bias[65:16];

  // Integral with symmetric clamp
  assign int_sum = 51'(integral_sum) + 51'(rnd);
  assign wl_pos  = signed'({20'd0, windup_limit});
  assign wl_neg  = -wl_pos;
  always_comb begin
    if (int_sum > wl_pos) begin
      integral_sum_next = wl_pos[31:0];
    end else if (int_sum < wl_neg) begin
      integral_sum_next = wl_neg[31:0];
    end else begin
      integral_sum_next = int_sum[31:0];
    end
  end

  // Difference filter: new term sits in acc, old term in the product
  assign fsum   = acc + 52'(prod) + 52'sd32768;
  assign fshift = fsum[51:16];
  always_comb begin
    if (fshift[35:31] != {5{fshift[31]}}) begin
      filt_next = fshift[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      filt_next = fshift[31:0];
    end
  end

  // Output clamp, upper bound checked first
  assign up_ext = 52'(output_upper);
  assign lo_ext = 52'(output_lower);
  always_comb begin
    if (acc > up_ext) begin
      drive_value = output_upper;
    end else if (acc < lo_ext) begin
      drive_value = output_lower;
    end else begin
      drive_value = acc[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sp   <= setpoint;
      meas <= measurement;
    end
    if (en) begin
      prod <= op_a * op_b;
      if (cw.ld_err) begin
        err <= err_next;
      end
      if (cw.ld_diff) begin
        diff <= {err[31], err} - {last_error[31], last_error};
      end
      if (cw.acc_from_p) begin
        acc <= 52'(prod);
      end else if (cw.acc_from_int) begin
        acc <= 52'(rnd) + 52'(integral_sum);
      end else if (cw.acc_add) begin
        acc <= acc + 52'(rnd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      integral_sum        <= '0;
      last_error          <= '0;
      filtered_difference <= '0;
    end else if (en) begin
      if (cw.upd_int) begin
        integral_sum <= integral_sum_next;
      end
      if (cw.upd_filt) begin
        filtered_difference <= filt_next;
      end
      if (cw.finish) begin
        last_error <= err;
      end
    end
  end

endmodule

[design/pid_controller_step_core.sv]
// PID controller step in signed Q16.16 with a clamped integral and a low-pass
// filtered error difference. A control step runs the program in the control
// store after its transfer on the input channel, and a new item is taken only
// once the previous one has left the program; a clear command gives no result.
// One shared 33 x 33 multiplier serves the five products in turn, one per step.
// A finished result waits in the output register while the next item is taken;
// configuration writes belong to idle periods.
module pid_controller_step_core
  import pidcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic signed [31:0] setpoint,
  input  logic signed [31:0] measurement,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KI    = 3'd1;
  localparam logic [2:0] REG_KD    = 3'd2;
  localparam logic [2:0] REG_WL    = 3'd3;
  localparam logic [2:0] REG_UPPER = 3'd4;
  localparam logic [2:0] REG_LOWER = 3'd5;

  logic signed [31:0] proportional_gain;
  logic signed [31:0] integral_gain;
  logic signed [31:0] derivative_gain;
  logic        [30:0] windup_limit;
  logic signed [31:0] output_upper;
  logic signed [31:0] output_lower;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              cmd_reg;
  ctrl_word_t        cw;
  logic              accept;
  logic              stall;
  logic              advance;
  logic              quit;
  logic signed [31:0] drive_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      proportional_gain <= 32'sd65536;
      integral_gain     <= '0;
      derivative_gain   <= '0;
      windup_limit      <= 31'd6553600;
      output_upper      <= 32'sd6553600;
      output_lower      <= -32'sd6553600;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KP:    proportional_gain <= cfg_data;
        REG_KI:    integral_gain     <= cfg_data;
        REG_KD:    derivative_gain   <= cfg_data;
        REG_WL:    windup_limit      <= cfg_data[30:0];
        REG_UPPER: output_upper      <= cfg_data;
        REG_LOWER: output_lower      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cw       = ucode(step);
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  // hold the last step while the previous result is still waiting
  assign stall    = cw.finish && out_valid && !out_ready;
  assign advance  = busy && !stall;
  assign quit     = (cw.clr_jump && cmd_reg) || cw.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      step    <= '0;
      cmd_reg <= 1'b0;
    end else if (accept) begin
      busy    <= 1'b1;
      step    <= '0;
      cmd_reg <= command;
    end else if (advance) begin
      if (quit) begin
        busy <= 1'b0;
        step <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && cw.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cw.finish) begin
      drive <= drive_value;
    end
  end

  pidcs_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .en                (advance),
    .clear             (advance && cw.clr_jump && cmd_reg),
    .load              (accept),
    .cw                (cw),
    .setpoint          (setpoint),
    .measurement       (measurement),
    .proportional_gain (proportional_gain),
    .integral_gain     (integral_gain),
    .derivative_gain   (derivative_gain),
    .windup_limit      (windup_limit),
    .output_upper      (output_upper),
    .output_lower      (output_lower),
    .drive_value       (drive_value)
  );

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && step == '0)
    else $error("accepted item did not start the program at step zero");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == '0)
    else $error("step counter not parked while idle");

  a_result: assert property (@(posedge clk) disable iff (rst)
    advance && cw.finish |=> out_valid && !busy)
    else $error("finished program did not present a result");

  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    advance && cw.clr_jump && cmd_reg && !out_valid |=> !out_valid && !busy)
    else $error("clear command produced a result or kept running");

endmodule
